>>> rtl/core/cbt_pkg.sv
// ---------------------------------------------------------------------------
// cbt_pkg: shared types and constants for the cosine blend trajectory
// Fixed-point formats, pipeline stage map, CORDIC angle table and the
// register map of the configuration port.
// ---------------------------------------------------------------------------
package cbt_pkg;

    // Fixed-point format of positions and times
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    // Internal constants (30 fractional bits; DUR_RESET is 1.0 in Q16.16)
    localparam int ONE_Q30             = 1 << 30;
    localparam int GAIN_Q30            = 652032874;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [31:0] DUR_RESET  = 32'(1 << FRAC_BITS);

    // Output scaling shifts
    localparam int VEL_SHIFT = 61 - FRAC_BITS;
    localparam int ACC_SHIFT = 91 - 2 * FRAC_BITS;

    // Divider chain geometry
    localparam int RAT_N  = 31;
    localparam int QUO_N  = ACC_SHIFT + 1;
    localparam int QUO_LO = QUO_N / 2;
    localparam int REM_W  = 64;
    localparam int ACC_W  = 80;
    localparam int PROD_W = 95;
    localparam int ASUM_W = QUO_N + 32;
    localparam int CW     = 34;

    // Pipeline stage map
    localparam int S_IN    = 0;
    localparam int S_FOLD  = S_IN + RAT_N + 1;
    localparam int S_THETA = S_FOLD + 1;
    localparam int S_CLAMP = S_THETA + CORDIC_N + 1;
    localparam int S_MUL   = S_CLAMP + 1;
    localparam int S_PL    = S_MUL + 1;
    localparam int S_PH    = S_PL + 1;
    localparam int S_PRE   = S_PH + 1;
    localparam int S_X1    = S_PRE + QUO_N + 1;
    localparam int S_OUT   = S_X1 + 1;
    localparam int PIPE_N  = S_OUT + 1;

    // Register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_DUR   = 2'd2;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [ACC_W-1:0] acc;
    } div_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic        over;
        logic        flip;
        logic        neg_v;
        logic        neg_a;
        logic        sat_v;
        logic        sat_a;
        logic [31:0] pos;
    } side_t;

    // Arctangent of 2^-i, 30 fractional bits
    function automatic logic signed [CW-1:0] cordic_angle(input logic [4:0] i);
        logic signed [CW-1:0] a;
        case (i)
            5'd0:    a = CW'(843314856);
            5'd1:    a = CW'(497837829);
            5'd2:    a = CW'(263043836);
            5'd3:    a = CW'(133525158);
            5'd4:    a = CW'(67021686);
            5'd5:    a = CW'(33543515);
            5'd6:    a = CW'(16775850);
            5'd7:    a = CW'(8388437);
            5'd8:    a = CW'(4194282);
            5'd9:    a = CW'(2097149);
            5'd10:   a = CW'(1048575);
            5'd11:   a = CW'(524287);
            5'd12:   a = CW'(262143);
            5'd13:   a = CW'(131071);
            5'd14:   a = CW'(65535);
            5'd15:   a = CW'(32767);
            5'd16:   a = CW'(16383);
            5'd17:   a = CW'(8191);
            5'd18:   a = CW'(4095);
            5'd19:   a = CW'(2047);
            5'd20:   a = CW'(1023);
            5'd21:   a = CW'(511);
            5'd22:   a = CW'(255);
            5'd23:   a = CW'(127);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/cbt_div_cell.sv
// ---------------------------------------------------------------------------
// cbt_div_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
// ---------------------------------------------------------------------------
module cbt_div_cell (
    input  logic                     clk,
    input  logic                     en,
    input  logic [cbt_pkg::REM_W-1:0] divisor,
    input  cbt_pkg::div_t            din,
    output cbt_pkg::div_t            dout
);

    cbt_pkg::div_t            dout_reg;
    cbt_pkg::div_t            dout_next;
    logic [cbt_pkg::REM_W:0]  rem_sh;
    logic [cbt_pkg::REM_W:0]  rem_sub;
    logic                     q;

    // Trial subtract
    always_comb
    begin
        rem_sh         = {din.rem, din.acc[cbt_pkg::ACC_W-1]};
        rem_sub        = rem_sh - {1'b0, divisor};
        q              = rem_sh >= {1'b0, divisor};
        dout_next.rem  = q ? rem_sub[cbt_pkg::REM_W-1:0] : rem_sh[cbt_pkg::REM_W-1:0];
        dout_next.acc  = {din.acc[cbt_pkg::ACC_W-2:0], q};
    end

    // Hand the step to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> rtl/core/cbt_cordic_cell.sv
// ---------------------------------------------------------------------------
// cbt_cordic_cell: one CORDIC rotation step
// Rotates the vector toward the residual angle by arctan(2^-step) using
// floor (arithmetic) shifts.
// ---------------------------------------------------------------------------
module cbt_cordic_cell (
    input  logic              clk,
    input  logic              en,
    input  logic [4:0]        step,
    input  cbt_pkg::cordic_t  din,
    output cbt_pkg::cordic_t  dout
);

    cbt_pkg::cordic_t              dout_reg;
    cbt_pkg::cordic_t              dout_next;
    logic signed [cbt_pkg::CW-1:0] dx;
    logic signed [cbt_pkg::CW-1:0] dy;
    logic signed [cbt_pkg::CW-1:0] ang;

    // Rotate by the sign of the residual angle
    always_comb
    begin
        dx  = $signed(din.y) >>> step;
        dy  = $signed(din.x) >>> step;
        ang = cbt_pkg::cordic_angle(step);
        if (!din.z[cbt_pkg::CW-1])
        begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - ang;
        end
        else
        begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + ang;
        end
    end

    // Hand the vector to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> rtl/core/cosine_blend_trajectory.sv
// ---------------------------------------------------------------------------
// cosine_blend_trajectory: half-cosine point-to-point motion profile
// Fully pipelined Q16.16 position, velocity and acceleration generator.
// ---------------------------------------------------------------------------
// Usage:
//   Program start_position (0x0), end_position (0x4) and move_duration (0x8)
//   over the APB port while the pipeline is empty. Each beat on s_tdata is
//   one time value; each beat on m_tdata carries position, velocity and
//   acceleration for it, in the order of the input beats.
//   With default constants the pipeline holds a 31-cell ratio divider,
//   16 CORDIC cells and two 60-cell dividers for the velocity and
//   acceleration scaling, plus the multiply stages around them.
//   Throughput is one beat per cycle. All stages advance together; when the
//   receiver holds m_tready low with a beat waiting, the whole pipeline
//   holds and s_tready drops until the beat is taken.
//   Reset clears the pipeline valid bits and loads start = end = 0 and a
//   duration of 1.0.
// ---------------------------------------------------------------------------
module cosine_blend_trajectory (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbt_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] eval_time
    // Output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [95:0]                 m_tdata    // [31:0] position,
                                                   // [63:32] velocity,
                                                   // [95:64] acceleration
);

    localparam int QN = cbt_pkg::QUO_N;
    localparam int QL = cbt_pkg::QUO_LO;
    localparam int PW = cbt_pkg::PROD_W;
    localparam int AW = cbt_pkg::ASUM_W;

    // Configuration registers
    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic [31:0] dur_reg;
    logic [63:0] dur_sq_reg;
    logic [31:0] dur_eff;
    logic        cfg_wr;

    // Pipeline control
    logic                        en;
    logic [cbt_pkg::PIPE_N-1:0]  vld_reg;
    logic [cbt_pkg::PIPE_N-1:0]  vld_next;
    cbt_pkg::side_t              side_reg  [cbt_pkg::PIPE_N];
    cbt_pkg::side_t              side_next [cbt_pkg::PIPE_N];

    // Datapath registers
    logic [31:0]          t0_reg;
    logic [29:0]          folded_reg;
    logic [29:0]          folded_next;
    logic [31:0]          theta_reg;
    logic [61:0]          theta_sum;
    logic signed [31:0]   c_reg;
    logic signed [31:0]   s_reg;
    logic signed [31:0]   c_next;
    logic signed [31:0]   s_next;
    logic signed [63:0]   pm_reg;
    logic [62:0]          vm_reg;
    logic [62:0]          am_reg;
    logic [63:0]          vlo_reg;
    logic [63:0]          alo_reg;
    logic [30:0]          vhi_reg;
    logic [30:0]          ahi_reg;
    logic [PW-1:0]        nv_reg;
    logic [PW-1:0]        na_reg;
    cbt_pkg::div_t        pre_v_reg;
    cbt_pkg::div_t        pre_a_reg;
    cbt_pkg::div_t        pre_v_next;
    cbt_pkg::div_t        pre_a_next;
    logic [31:0]          vres_reg;
    logic [31:0]          vres_next;
    logic [QL+31:0]       alo2_reg;
    logic [QN-QL-1:0]     x2hi_reg;
    logic [95:0]          out_reg;
    logic [95:0]          out_next;

    // Combinational helpers
    logic signed [32:0]   diff;
    logic [32:0]          dabs;
    logic [30:0]          ratio;
    logic                 flip_in;
    logic signed [31:0]   cabs;
    logic signed [31:0]   sabs;
    logic [30:0]          h;
    logic signed [63:0]   pr;
    logic [63:0]          psh;
    logic [PW-1:0]        nsh;
    logic [PW-1:0]        vtop;
    logic [PW-1:0]        atop;
    logic                 sat_v_in;
    logic                 sat_a_in;
    logic [QN-1:0]        vq;
    logic [QN:0]          vr;
    logic [QN-1:0]        vmag;
    logic [QN-1:0]        vlim;
    logic [32:0]          vm33;
    logic [AW-1:0]        asum;
    logic [AW-1:0]        amag;
    logic [AW-1:0]        alim;
    logic [32:0]          am33;

    // Cell chains
    cbt_pkg::div_t        rdiv [cbt_pkg::RAT_N + 1];
    cbt_pkg::cordic_t     cor  [cbt_pkg::CORDIC_N + 1];
    cbt_pkg::div_t        vdiv [QN + 1];
    cbt_pkg::div_t        adiv [QN + 1];

    // -----------------------------------------------------------------------
    // Configuration port
    // -----------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign dur_eff = (dur_reg == '0) ? 32'd1 : dur_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            end_reg    <= '0;
            dur_reg    <= cbt_pkg::DUR_RESET;
            dur_sq_reg <= 64'(cbt_pkg::DUR_RESET) * 64'(cbt_pkg::DUR_RESET);
        end
        else
        begin
            dur_sq_reg <= 64'(dur_eff) * 64'(dur_eff);
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    cbt_pkg::REG_START: start_reg <= pwdata;
                    cbt_pkg::REG_END:   end_reg   <= pwdata;
                    cbt_pkg::REG_DUR:   dur_reg   <= pwdata;
                    default:            ;
                endcase
            end
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[3:2])
            cbt_pkg::REG_START: prdata = start_reg;
            cbt_pkg::REG_END:   prdata = end_reg;
            cbt_pkg::REG_DUR:   prdata = dur_reg;
            default:            prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Pipeline control: every stage advances unless the output beat stalls
    // -----------------------------------------------------------------------
    assign en       = !vld_reg[cbt_pkg::PIPE_N-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[cbt_pkg::PIPE_N-1];
    assign m_tdata  = out_reg;
    assign vld_next = {vld_reg[cbt_pkg::PIPE_N-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Side flags ride along with each beat
    always_comb
    begin
        side_next[0] = '0;
        for (int k = 1; k < cbt_pkg::PIPE_N; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[cbt_pkg::S_IN].over   = s_tdata > dur_eff;
        side_next[cbt_pkg::S_FOLD].flip = flip_in;
        side_next[cbt_pkg::S_MUL].neg_v = ((diff < 0) != (s_reg < 0)) && (diff != 0)
                                          && (s_reg != 0);
        side_next[cbt_pkg::S_MUL].neg_a = ((diff < 0) != (c_reg < 0)) && (diff != 0)
                                          && (c_reg != 0);
        side_next[cbt_pkg::S_PL].pos    = start_reg + psh[31:0];
        side_next[cbt_pkg::S_PRE].sat_v = sat_v_in;
        side_next[cbt_pkg::S_PRE].sat_a = sat_a_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
        end
    end

    // -----------------------------------------------------------------------
    // Ratio t/T with 30 fractional bits
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg <= s_tdata;
        end
    end

    assign rdiv[0].rem = 64'(t0_reg >> 1);
    assign rdiv[0].acc = {t0_reg[0], (cbt_pkg::ACC_W - 1)'(0)};

    for (genvar i = 0; i < cbt_pkg::RAT_N; i++)
    begin : g_rat
        cbt_div_cell u_cell (
            .clk     (clk),
            .en      (en),
            .divisor (64'(dur_eff)),
            .din     (rdiv[i]),
            .dout    (rdiv[i+1])
        );
    end

    // Fold into the first quarter and scale to an angle
    assign ratio       = rdiv[cbt_pkg::RAT_N].acc[30:0];
    assign flip_in     = ratio > 31'(1 << 29);
    assign folded_next = flip_in ? 30'(31'(1 << 30) - ratio) : ratio[29:0];
    assign theta_sum   = 62'(folded_reg) * 62'(cbt_pkg::PI_Q30) + 62'(1 << 29);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            folded_reg <= folded_next;
            theta_reg  <= theta_sum[61:30];
        end
    end

    // -----------------------------------------------------------------------
    // CORDIC rotation
    // -----------------------------------------------------------------------
    assign cor[0].x = cbt_pkg::CW'(cbt_pkg::GAIN_Q30);
    assign cor[0].y = '0;
    assign cor[0].z = cbt_pkg::CW'($signed({1'b0, theta_reg}));

    for (genvar i = 0; i < cbt_pkg::CORDIC_N; i++)
    begin : g_cor
        cbt_cordic_cell u_cell (
            .clk  (clk),
            .en   (en),
            .step (5'(i)),
            .din  (cor[i]),
            .dout (cor[i+1])
        );
    end

    // Clamp to [-1, 1] and undo the fold on the cosine
    always_comb
    begin
        if (cor[cbt_pkg::CORDIC_N].x > cbt_pkg::CW'(cbt_pkg::ONE_Q30))
            c_next = 32'(cbt_pkg::ONE_Q30);
        else if (cor[cbt_pkg::CORDIC_N].x < -cbt_pkg::CW'(cbt_pkg::ONE_Q30))
            c_next = -32'(cbt_pkg::ONE_Q30);
        else
            c_next = 32'(cor[cbt_pkg::CORDIC_N].x);
        if (side_reg[cbt_pkg::S_CLAMP-1].flip)
            c_next = -c_next;
        if (cor[cbt_pkg::CORDIC_N].y > cbt_pkg::CW'(cbt_pkg::ONE_Q30))
            s_next = 32'(cbt_pkg::ONE_Q30);
        else if (cor[cbt_pkg::CORDIC_N].y < -cbt_pkg::CW'(cbt_pkg::ONE_Q30))
            s_next = -32'(cbt_pkg::ONE_Q30);
        else
            s_next = 32'(cor[cbt_pkg::CORDIC_N].y);
    end

    // -----------------------------------------------------------------------
    // Products for position, velocity and acceleration
    // -----------------------------------------------------------------------
    assign diff = 33'(signed'(end_reg)) - 33'(signed'(start_reg));
    assign dabs = diff[32] ? 33'(-diff) : 33'(diff);
    assign cabs = c_reg[31] ? -c_reg : c_reg;
    assign sabs = s_reg[31] ? -s_reg : s_reg;
    assign h    = 31'((33'(32'(cbt_pkg::ONE_Q30)) - 33'(c_reg)) >> 1);
    assign pr   = pm_reg + 64'sd536870912;
    assign psh  = 64'(pr >>> 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= c_next;
            s_reg   <= s_next;
            pm_reg  <= 64'(diff) * 64'(signed'({1'b0, h}));
            vm_reg  <= 63'(dabs[31:0]) * 63'(sabs[30:0]);
            am_reg  <= 63'(dabs[31:0]) * 63'(cabs[30:0]);
            vlo_reg <= 64'(vm_reg[31:0]) * 64'(cbt_pkg::PI_Q30);
            alo_reg <= 64'(am_reg[31:0]) * 64'(cbt_pkg::PI_Q30);
            vhi_reg <= vm_reg[62:32];
            ahi_reg <= am_reg[62:32];
            nv_reg  <= ((PW'(vhi_reg) * PW'(cbt_pkg::PI_Q30)) << 32) + PW'(vlo_reg);
            na_reg  <= ((PW'(ahi_reg) * PW'(cbt_pkg::PI_Q30)) << 32) + PW'(alo_reg);
        end
    end

    // -----------------------------------------------------------------------
    // Divider setup: drop bits below the rounding point, flag overflow
    // -----------------------------------------------------------------------
    always_comb
    begin
        nsh            = nv_reg >> (cbt_pkg::VEL_SHIFT - 1);
        vtop           = nsh >> QN;
        atop           = na_reg >> QN;
        sat_v_in       = vtop >= PW'(dur_eff);
        sat_a_in       = atop >= PW'(dur_sq_reg);
        pre_v_next.rem = sat_v_in ? '0 : vtop[63:0];
        pre_v_next.acc = {nsh[QN-1:0], (cbt_pkg::ACC_W - QN)'(0)};
        pre_a_next.rem = sat_a_in ? '0 : atop[63:0];
        pre_a_next.acc = {na_reg[QN-1:0], (cbt_pkg::ACC_W - QN)'(0)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_v_reg <= pre_v_next;
            pre_a_reg <= pre_a_next;
        end
    end

    assign vdiv[0] = pre_v_reg;
    assign adiv[0] = pre_a_reg;

    for (genvar i = 0; i < QN; i++)
    begin : g_scale
        cbt_div_cell u_vcell (
            .clk     (clk),
            .en      (en),
            .divisor (64'(dur_eff)),
            .din     (vdiv[i]),
            .dout    (vdiv[i+1])
        );
        cbt_div_cell u_acell (
            .clk     (clk),
            .en      (en),
            .divisor (dur_sq_reg),
            .din     (adiv[i]),
            .dout    (adiv[i+1])
        );
    end

    // -----------------------------------------------------------------------
    // Velocity rounding and saturation; first acceleration partial product
    // -----------------------------------------------------------------------
    always_comb
    begin
        vq   = vdiv[QN].acc[QN-1:0];
        vr   = (QN+1)'(vq) + (QN+1)'(1);
        vmag = vr[QN:1];
        vlim = side_reg[cbt_pkg::S_X1-1].neg_v ? QN'(33'h100000000 >> 1)
                                               : QN'((33'h100000000 >> 1) - 33'd1);
        if (side_reg[cbt_pkg::S_X1-1].sat_v || vmag > vlim)
            vm33 = 33'(vlim);
        else
            vm33 = 33'(vmag);
        vres_next = side_reg[cbt_pkg::S_X1-1].neg_v ? 32'(-vm33) : vm33[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vres_reg <= vres_next;
            alo2_reg <= (QL+32)'(adiv[QN].acc[QL-1:0]) * (QL+32)'(cbt_pkg::PI_Q30);
            x2hi_reg <= adiv[QN].acc[QN-1:QL];
        end
    end

    // -----------------------------------------------------------------------
    // Acceleration, end-of-move hold and output register
    // -----------------------------------------------------------------------
    always_comb
    begin
        asum = ((AW'(x2hi_reg) * AW'(cbt_pkg::PI_Q30)) << QL) + AW'(alo2_reg)
               + (AW'(1) << (cbt_pkg::ACC_SHIFT - 1));
        amag = asum >> cbt_pkg::ACC_SHIFT;
        alim = side_reg[cbt_pkg::S_OUT-1].neg_a ? AW'(33'h100000000 >> 1)
                                                : AW'((33'h100000000 >> 1) - 33'd1);
        if (side_reg[cbt_pkg::S_OUT-1].sat_a || amag > alim)
            am33 = 33'(alim);
        else
            am33 = 33'(amag);
        if (side_reg[cbt_pkg::S_OUT-1].over)
        begin
            out_next = {64'd0, end_reg};
        end
        else
        begin
            out_next[31:0]  = side_reg[cbt_pkg::S_OUT-1].pos;
            out_next[63:32] = vres_reg;
            out_next[95:64] = side_reg[cbt_pkg::S_OUT-1].neg_a ? 32'(-am33) : am33[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && side_reg[cbt_pkg::S_OUT].over) |-> (m_tdata[95:32] == 64'd0))
        else $error("velocity or acceleration nonzero past end of move");

    a_over_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && side_reg[cbt_pkg::S_OUT].over) |-> (m_tdata[31:0] == end_reg))
        else $error("position not held at end past end of move");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for cosine_blend_trajectory
// Drives eval_time beats, predicts position, velocity and acceleration with
// an independent fixed-point profile calculator, and compares every output
// beat in order. A directed table comes first, then randomized blocks under
// three idling patterns, with register changes between blocks.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE  = 2'd3;   // unmapped register slot
    localparam int         IDLE_LIMIT = 5000;
    localparam int         DRAIN_CYC  = 200;
    localparam int         BLOCKS     = 6;
    localparam int         BLOCK_LEN  = 97;

    typedef struct packed {
        logic [31:0] acc;
        logic [31:0] vel;
        logic [31:0] pos;
    } profile_t;

    typedef enum logic [1:0] { ROW_TIME, ROW_TIME_KNOWN, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        profile_t    known;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [cbt_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] eval_time
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;     // [31:0] position, [63:32] velocity, [95:64] acceleration

    // Register shadow used by the profile calculator
    logic [31:0] start_q;
    logic [31:0] end_q;
    logic [31:0] dur_q;

    profile_t    expected_beats[$];
    int          error_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold;
    longint      arctan_q30[24];

    cosine_blend_trajectory DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        arctan_q30 = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                       16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                       262143, 131071, 65535, 32767, 16383, 8191,
                       4095, 2047, 1023, 511, 255, 127};
    end

    // Clamp a magnitude and apply the sign, 32-bit two's complement result
    function automatic logic [31:0] saturate32(logic [127:0] mag, bit neg);
        logic [127:0] lim;
        logic [31:0]  m;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        m = (mag > lim) ? lim[31:0] : mag[31:0];
        return neg ? 32'(-m) : m;
    endfunction

    // Profile at time t for the current register values
    function automatic profile_t profile_at(logic [31:0] t);
        profile_t     r;
        logic [63:0]  dur;
        logic [63:0]  ratio;
        logic [63:0]  folded;
        logic [63:0]  dmag;
        logic [127:0] w;
        logic [127:0] half;
        bit           flip;
        longint       st, en, diff, theta, x, y, z, dx, dy, c, s, h;
        dur = (dur_q == 0) ? 64'd1 : {32'd0, dur_q};
        st = longint'($signed(start_q));
        en = longint'($signed(end_q));
        if ({32'd0, t} > dur)
        begin
            r.pos = end_q;
            r.vel = '0;
            r.acc = '0;
            return r;
        end
        diff = en - st;
        dmag = (diff < 0) ? 64'(-diff) : 64'(diff);

        // Phase ratio with 30 fraction bits, folded about the midpoint
        ratio = ({32'd0, t} << 30) / dur;
        flip = ratio > (64'd1 << 29);
        folded = flip ? (64'd1 << 30) - ratio : ratio;
        theta = longint'((folded * 64'(cbt_pkg::PI_Q30) + (64'd1 << 29)) >> 30);

        // Rotate from the gain-compensated unit vector
        x = cbt_pkg::GAIN_Q30;
        y = 0;
        z = theta;
        for (int i = 0; i < cbt_pkg::CORDIC_N; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_q30[i];
            end
            else
            begin
                x += dx; y -= dy; z += arctan_q30[i];
            end
        end
        c = (x > cbt_pkg::ONE_Q30) ? cbt_pkg::ONE_Q30 :
            (x < -cbt_pkg::ONE_Q30) ? -cbt_pkg::ONE_Q30 : x;
        s = (y > cbt_pkg::ONE_Q30) ? cbt_pkg::ONE_Q30 :
            (y < -cbt_pkg::ONE_Q30) ? -cbt_pkg::ONE_Q30 : y;
        if (flip)
            c = -c;

        h = (cbt_pkg::ONE_Q30 - c) >>> 1;
        r.pos = 32'(st + ((diff * h + (64'sd1 <<< 29)) >>> 30));

        w = (128'(dmag) * 128'((s < 0) ? -s : s) * 128'(cbt_pkg::PI_Q30)) / 128'(dur);
        half = 128'd1 << (cbt_pkg::VEL_SHIFT - 1);
        r.vel = saturate32((w + half) >> cbt_pkg::VEL_SHIFT,
                           ((diff < 0) != (s < 0)) && diff != 0 && s != 0);

        w = (128'(dmag) * 128'((c < 0) ? -c : c) * 128'(cbt_pkg::PI_Q30)) / 128'(dur);
        w = (w / 128'(dur)) * 128'(cbt_pkg::PI_Q30);
        half = 128'd1 << (cbt_pkg::ACC_SHIFT - 1);
        r.acc = saturate32((w + half) >> cbt_pkg::ACC_SHIFT,
                           ((diff < 0) != (c < 0)) && diff != 0 && c != 0);
        return r;
    endfunction

    // Register write: setup then access phase; mirror into the shadow
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= cbt_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cbt_pkg::REG_START: start_q = value;
            cbt_pkg::REG_END:   end_q   = value;
            cbt_pkg::REG_DUR:   dur_q   = value;
            default: ;
        endcase
    endtask

    // Drop the input and pause the sender until every expected beat is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Offer one time beat from a falling edge, hold until taken, then record
    // the expectation; valid stays up so the next beat can follow at once
    task automatic send_time(logic [31:0] t, bit known, profile_t known_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do
            @(posedge clk);
        while (!s_tready);
        expected_beats.push_back(known ? known_val : profile_at(t));
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_position();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(3);
            2:       return $urandom_range(1, 2000);
            3:       return 32'($urandom_range(1, 64)) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        logic [31:0] d;
        int          roll;
        d = (dur_q == 0) ? 32'd1 : dur_q;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(d, 0);
        else if (roll < 80)
            return d + 32'($signed($urandom_range(2)) - 1);
        return $urandom;
    endfunction

    // Receiver: idle at random, or hold off for a counted stretch
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each output beat against the oldest expectation
    always @(posedge clk)
    begin
        profile_t got;
        profile_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = profile_t'(m_tdata);
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected output beat %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.pos !== want.pos)
                begin
                    $display("%0t: position expected %h actual %h", $time, want.pos, got.pos);
                    error_count++;
                end
                if (got.vel !== want.vel)
                begin
                    $display("%0t: velocity expected %h actual %h", $time, want.vel, got.vel);
                    error_count++;
                end
                if (got.acc !== want.acc)
                begin
                    $display("%0t: acceleration expected %h actual %h",
                             $time, want.acc, got.acc);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat and no register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t     rows[$];
        profile_t zero;
        zero = '0;
        rows = '{
            // reset values: start = end = 0 gives an all-zero profile
            '{ROW_TIME_KNOWN, cbt_pkg::REG_START, 32'h0000_0000, zero},
            '{ROW_TIME_KNOWN, cbt_pkg::REG_START, 32'h0001_0000, zero},
            '{ROW_TIME_KNOWN, cbt_pkg::REG_START, 32'hFFFF_FFFF, zero},
            // full-scale move over one LSB of time
            '{ROW_WRITE, cbt_pkg::REG_START, 32'h8000_0000, zero},
            '{ROW_WRITE, cbt_pkg::REG_END,   32'h7FFF_FFFF, zero},
            '{ROW_WRITE, cbt_pkg::REG_DUR,   32'h0000_0001, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h0000_0000, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h0000_0001, zero},
            '{ROW_TIME_KNOWN, cbt_pkg::REG_START, 32'h0000_0002,
              '{32'd0, 32'd0, 32'h7FFF_FFFF}},
            '{ROW_TIME_KNOWN, cbt_pkg::REG_START, 32'hFFFF_FFFF,
              '{32'd0, 32'd0, 32'h7FFF_FFFF}},
            // zero duration acts as one LSB
            '{ROW_WRITE, cbt_pkg::REG_DUR,   32'h0000_0000, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h0000_0001, zero},
            '{ROW_TIME_KNOWN, cbt_pkg::REG_START, 32'h0000_0002,
              '{32'd0, 32'd0, 32'h7FFF_FFFF}},
            // downward move over the longest duration
            '{ROW_WRITE, cbt_pkg::REG_START, 32'h7FFF_FFFF, zero},
            '{ROW_WRITE, cbt_pkg::REG_END,   32'h8000_0000, zero},
            '{ROW_WRITE, cbt_pkg::REG_DUR,   32'hFFFF_FFFF, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h0000_0000, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h7FFF_FFFF, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h8000_0000, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'hFFFF_FFFF, zero},
            // ordinary move of 10.0 over 1.0 s; unmapped slot must be ignored
            '{ROW_WRITE, cbt_pkg::REG_START, 32'h0000_0000, zero},
            '{ROW_WRITE, cbt_pkg::REG_END,   32'h000A_0000, zero},
            '{ROW_WRITE, cbt_pkg::REG_DUR,   32'h0001_0000, zero},
            '{ROW_WRITE, REG_SPARE,          32'h1234_5678, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h0000_4000, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h0000_8000, zero},
            '{ROW_TIME,  cbt_pkg::REG_START, 32'h0000_C000, zero},
            '{ROW_TIME_KNOWN, cbt_pkg::REG_START, 32'h0001_0001,
              '{32'd0, 32'd0, 32'h000A_0000}}
        };

        // Hold every input at a known value through reset
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        recv_hold = 0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 8;
        recv_idle_pct = 66;
        start_q = '0;
        end_q = '0;
        dur_q = cbt_pkg::DUR_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_WRITE)
            begin
                drain_results();
                reg_write(rows[i].reg_idx, rows[i].value);
            end
            else
                send_time(rows[i].value, rows[i].kind == ROW_TIME_KNOWN, rows[i].known);
        end

        // Random blocks under three idling patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 66 : 0;
            recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 8 : 0;
            for (int blk = 0; blk < BLOCKS; blk++)
            begin
                drain_results();
                reg_write(cbt_pkg::REG_START, pick_position());
                reg_write(cbt_pkg::REG_END, pick_position());
                reg_write(cbt_pkg::REG_DUR, pick_duration());
                // long receiver stall so the pipeline fills and backs up
                if (mode == 2 && blk == 0)
                    recv_hold = 400;
                for (int n = 0; n < BLOCK_LEN; n++)
                    send_time(pick_time(), 1'b0, zero);
            end
        end

        drain_results();
        repeat (DRAIN_CYC) @(posedge clk);
        if (error_count == 0 && expected_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cbt_pkg.sv
rtl/core/cbt_div_cell.sv
rtl/core/cbt_cordic_cell.sv
rtl/core/cosine_blend_trajectory.sv
tb/testbench.sv
